// ----- sv/frlt_pkg.sv -----
package frlt_pkg;

    // Operand width
    localparam int VALUE_BITS = 31;
    localparam int CNT_BITS   = $clog2(VALUE_BITS);

    // Microprogram size and step labels
    localparam int PROG_LEN = 13;
    localparam int PC_BITS  = $clog2(PROG_LEN);

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [CNT_BITS-1:0]   cnt_t;
    typedef logic [PC_BITS-1:0]    pc_t;

    localparam pc_t PC_CHECK_DEN = pc_t'(0);
    localparam pc_t PC_CHECK_NUM = pc_t'(1);
    localparam pc_t PC_EVEN_ALL  = pc_t'(2);
    localparam pc_t PC_EVEN_A    = pc_t'(3);
    localparam pc_t PC_EVEN_B    = pc_t'(4);
    localparam pc_t PC_SUB       = pc_t'(5);
    localparam pc_t PC_INIT_N    = pc_t'(6);
    localparam pc_t PC_DIV_N     = pc_t'(7);
    localparam pc_t PC_INIT_D    = pc_t'(8);
    localparam pc_t PC_DIV_D     = pc_t'(9);
    localparam pc_t PC_DONE      = pc_t'(10);
    localparam pc_t PC_ERR       = pc_t'(11);
    localparam pc_t PC_ZERO      = pc_t'(12);

    // Datapath operations; shift operations act only when their test holds
    typedef enum logic [3:0] {
        OP_NOP,
        OP_SHIFT_ALL,
        OP_SHIFT_A,
        OP_SHIFT_B,
        OP_SUB,
        OP_DIV_INIT,
        OP_DIV_N,
        OP_DIV_D,
        OP_DONE_OK,
        OP_DONE_ERR,
        OP_DONE_ZERO
    } op_t;

    // Jump conditions, tested on register values at the start of a step
    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_DEN_ZERO,
        C_NUM_ZERO,
        C_BOTH_EVEN,
        C_A_EVEN,
        C_B_EVEN,
        C_A_NE_B,
        C_CNT_MORE
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } ctrl_word_t;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic den_zero;
        logic num_zero;
        logic both_even;
        logic a_even;
        logic b_even;
        logic a_ne_b;
        logic cnt_last;
    } dp_status_t;

    typedef struct packed {
        value_t numerator_in;
        value_t denominator_in;
    } frlt_in_t;

    typedef struct packed {
        value_t numerator_out;
        value_t denominator_out;
        logic   zero_denominator;
    } frlt_out_t;

endpackage

// ----- sv/fraction_reduce_lowest_terms.sv -----
// Reduces a non-negative fraction to lowest terms. Drive operand and pulse start
// while busy is low; the transfer happens at that edge and busy rises. One result
// appears on result for a single cycle with done high, then stays on the port until
// the next one; the receiver cannot stall it. A zero denominator returns 0/1 with
// zero_denominator set; a zero numerator returns 0/1. Otherwise the sequencer makes
// the two checks, shifts common factors of two out of both terms, runs the binary
// GCD loop (stripping the remaining factors of two from each part, then per pass a
// subtract followed by shifts of the difference) and divides both terms by the GCD.
// The sequencer is microcoded and issues one control word per cycle to a single
// datapath shared by all steps.
module fraction_reduce_lowest_terms
    import frlt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  frlt_in_t  operand,
    output logic      done,
    output frlt_out_t result
);

    pc_t        pc;
    ctrl_word_t word;
    dp_status_t status;
    logic       load;
    op_t        exec_op;

    frlt_ucode_rom u_rom (
        .pc   (pc),
        .word (word)
    );

    frlt_sequencer u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .word    (word),
        .status  (status),
        .pc      (pc),
        .busy    (busy),
        .load    (load),
        .exec_op (exec_op),
        .done    (done)
    );

    frlt_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (load),
        .operand (operand),
        .exec_op (exec_op),
        .status  (status),
        .result  (result)
    );

`ifndef ASSERT_OFF
    // A result strobe ends the item
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done raised while busy");

    // A transfer starts the sequencer
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> busy)
        else $error("busy not raised after transfer");

    // Binary GCD subtract only sees odd operands
    a_sub_odd: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_op == OP_SUB) |-> (u_dp.a_reg[0] && u_dp.b_reg[0]))
        else $error("subtract step with even operand");

    // Denominator of a result is never zero
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.denominator_out != '0))
        else $error("zero denominator in result");
`endif

endmodule

// ----- sv/frlt_ucode_rom.sv -----
module frlt_ucode_rom
    import frlt_pkg::*;
(
    input  pc_t        pc,
    output ctrl_word_t word
);

    // Microprogram: binary GCD on the odd part, then divide both terms
    always_comb
    begin
        case (pc)
            PC_CHECK_DEN: word = '{op: OP_NOP,       cond: C_DEN_ZERO,  target: PC_ERR};
            PC_CHECK_NUM: word = '{op: OP_NOP,       cond: C_NUM_ZERO,  target: PC_ZERO};
            PC_EVEN_ALL:  word = '{op: OP_SHIFT_ALL, cond: C_BOTH_EVEN, target: PC_EVEN_ALL};
            PC_EVEN_A:    word = '{op: OP_SHIFT_A,   cond: C_A_EVEN,    target: PC_EVEN_A};
            PC_EVEN_B:    word = '{op: OP_SHIFT_B,   cond: C_B_EVEN,    target: PC_EVEN_B};
            PC_SUB:       word = '{op: OP_SUB,       cond: C_A_NE_B,    target: PC_EVEN_B};
            PC_INIT_N:    word = '{op: OP_DIV_INIT,  cond: C_NEXT,      target: PC_DIV_N};
            PC_DIV_N:     word = '{op: OP_DIV_N,     cond: C_CNT_MORE,  target: PC_DIV_N};
            PC_INIT_D:    word = '{op: OP_DIV_INIT,  cond: C_NEXT,      target: PC_DIV_D};
            PC_DIV_D:     word = '{op: OP_DIV_D,     cond: C_CNT_MORE,  target: PC_DIV_D};
            PC_DONE:      word = '{op: OP_DONE_OK,   cond: C_ALWAYS,    target: PC_CHECK_DEN};
            PC_ERR:       word = '{op: OP_DONE_ERR,  cond: C_ALWAYS,    target: PC_CHECK_DEN};
            PC_ZERO:      word = '{op: OP_DONE_ZERO, cond: C_ALWAYS,    target: PC_CHECK_DEN};
            default:      word = '{op: OP_DONE_ERR,  cond: C_ALWAYS,    target: PC_CHECK_DEN};
        endcase
    end

endmodule

// ----- sv/frlt_sequencer.sv -----
module frlt_sequencer
    import frlt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  ctrl_word_t word,
    input  dp_status_t status,
    output pc_t        pc,
    output logic       busy,
    output logic       load,
    output op_t        exec_op,
    output logic       done
);

    pc_t  pc_reg;
    pc_t  pc_next;
    logic busy_reg;
    logic busy_next;
    logic done_reg;
    logic done_next;
    logic cond_met;
    logic finish;

    assign load    = start && !busy_reg;
    assign exec_op = busy_reg ? word.op : OP_NOP;
    assign finish  = (exec_op == OP_DONE_OK) || (exec_op == OP_DONE_ERR)
                  || (exec_op == OP_DONE_ZERO);

    // Evaluate the jump condition of the current step
    always_comb
    begin
        case (word.cond)
            C_NEXT:      cond_met = 1'b0;
            C_ALWAYS:    cond_met = 1'b1;
            C_DEN_ZERO:  cond_met = status.den_zero;
            C_NUM_ZERO:  cond_met = status.num_zero;
            C_BOTH_EVEN: cond_met = status.both_even;
            C_A_EVEN:    cond_met = status.a_even;
            C_B_EVEN:    cond_met = status.b_even;
            C_A_NE_B:    cond_met = status.a_ne_b;
            C_CNT_MORE:  cond_met = !status.cnt_last;
            default:     cond_met = 1'b0;
        endcase
    end

    // Advance the step counter, start on a transfer, stop on a done step
    always_comb
    begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (load)
        begin
            pc_next   = PC_CHECK_DEN;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            pc_next = cond_met ? word.target : pc_reg + pc_t'(1);
            if (finish)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                pc_next   = PC_CHECK_DEN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= PC_CHECK_DEN;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign pc   = pc_reg;
    assign busy = busy_reg;
    assign done = done_reg;

endmodule

// ----- sv/frlt_datapath.sv -----
module frlt_datapath
    import frlt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  frlt_in_t   operand,
    input  op_t        exec_op,
    output dp_status_t status,
    output frlt_out_t  result
);

    value_t    a_reg, a_next;
    value_t    b_reg, b_next;
    value_t    n_reg, n_next;
    value_t    d_reg, d_next;
    value_t    r_reg, r_next;
    cnt_t      cnt_reg, cnt_next;
    frlt_out_t result_reg, result_next;

    logic                  a_gt_b;
    value_t                a_minus_b;
    value_t                b_minus_a;
    logic                  div_msb;
    logic [VALUE_BITS:0]   rem_ext;
    logic [VALUE_BITS:0]   divisor_ext;
    logic [VALUE_BITS:0]   rem_diff;
    logic                  div_ge;
    value_t                div_rem;

    // Flags for the sequencer
    assign status.den_zero  = (d_reg == '0);
    assign status.num_zero  = (n_reg == '0);
    assign status.both_even = !a_reg[0] && !b_reg[0];
    assign status.a_even    = !a_reg[0];
    assign status.b_even    = !b_reg[0];
    assign status.a_ne_b    = (a_reg != b_reg);
    assign status.cnt_last  = (cnt_reg == cnt_t'(VALUE_BITS - 1));

    // Shared subtractors for the GCD step
    assign a_gt_b    = a_reg > b_reg;
    assign a_minus_b = a_reg - b_reg;
    assign b_minus_a = b_reg - a_reg;

    // One restoring division step, dividend bits shift out of n or d
    assign div_msb     = (exec_op == OP_DIV_D) ? d_reg[VALUE_BITS-1] : n_reg[VALUE_BITS-1];
    assign rem_ext     = {r_reg, div_msb};
    assign divisor_ext = {1'b0, a_reg};
    assign div_ge      = rem_ext >= divisor_ext;
    assign rem_diff    = rem_ext - divisor_ext;
    assign div_rem     = div_ge ? rem_diff[VALUE_BITS-1:0] : rem_ext[VALUE_BITS-1:0];

    // Next-value logic per operation
    always_comb
    begin
        a_next      = a_reg;
        b_next      = b_reg;
        n_next      = n_reg;
        d_next      = d_reg;
        r_next      = r_reg;
        cnt_next    = cnt_reg;
        result_next = result_reg;
        if (load)
        begin
            a_next = operand.numerator_in;
            n_next = operand.numerator_in;
            b_next = operand.denominator_in;
            d_next = operand.denominator_in;
        end
        else
        begin
            case (exec_op)
                OP_SHIFT_ALL:
                begin
                    if (status.both_even)
                    begin
                        a_next = a_reg >> 1;
                        b_next = b_reg >> 1;
                        n_next = n_reg >> 1;
                        d_next = d_reg >> 1;
                    end
                end
                OP_SHIFT_A:
                begin
                    if (status.a_even)
                    begin
                        a_next = a_reg >> 1;
                    end
                end
                OP_SHIFT_B:
                begin
                    if (status.b_even)
                    begin
                        b_next = b_reg >> 1;
                    end
                end
                OP_SUB:
                begin
                    if (a_gt_b)
                    begin
                        a_next = b_reg;
                        b_next = a_minus_b;
                    end
                    else
                    begin
                        b_next = b_minus_a;
                    end
                end
                OP_DIV_INIT:
                begin
                    r_next   = '0;
                    cnt_next = '0;
                end
                OP_DIV_N:
                begin
                    r_next   = div_rem;
                    n_next   = {n_reg[VALUE_BITS-2:0], div_ge};
                    cnt_next = cnt_reg + cnt_t'(1);
                end
                OP_DIV_D:
                begin
                    r_next   = div_rem;
                    d_next   = {d_reg[VALUE_BITS-2:0], div_ge};
                    cnt_next = cnt_reg + cnt_t'(1);
                end
                OP_DONE_OK:
                begin
                    result_next.numerator_out    = n_reg;
                    result_next.denominator_out  = d_reg;
                    result_next.zero_denominator = 1'b0;
                end
                OP_DONE_ERR:
                begin
                    result_next.numerator_out    = '0;
                    result_next.denominator_out  = value_t'(1);
                    result_next.zero_denominator = 1'b1;
                end
                OP_DONE_ZERO:
                begin
                    result_next.numerator_out    = '0;
                    result_next.denominator_out  = value_t'(1);
                    result_next.zero_denominator = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Hold the division counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        n_reg      <= n_next;
        d_reg      <= d_next;
        r_reg      <= r_next;
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule
